>>> sv/smvf_pkg.sv
// ---------------------------------------------------------------------------
// smvf_pkg: shared constants and helpers of the sliding median filter
// Queue depth, rank width and the bit counter used by the rank stage.
// ---------------------------------------------------------------------------
package smvf_pkg;

	// widest window supported; order rows are padded to this many bits
	localparam int unsigned MAX_ROW     = 32;
	localparam int unsigned GROUP_W     = 8;
	localparam int unsigned GROUPS      = MAX_ROW / GROUP_W;
	localparam int unsigned PART_W      = 4;
	localparam int unsigned RANK_W      = 6;
	localparam int unsigned QUEUE_DEPTH = 2;

	// number of set bits in one 8-bit group
	function automatic logic [PART_W-1:0] count8(input logic [GROUP_W-1:0] v);
		logic [PART_W-1:0] acc;
		acc = '0;
		for (int k = 0; k < GROUP_W; k++) begin
			acc = acc + PART_W'(v[k]);
		end
		return acc;
	endfunction

endpackage

>>> sv/sliding_median_velocity_filter.sv
// Path: an accepted beat is stored in a queue slot, then registered in s1, s2 and the output stage.
// Throughput: one sample per cycle while the queue has room; the window
//   update and WINDOW-1 compares against the new sample are the front's per-beat loop.
// Reset: arst_n clears the window to all zeros, so early medians count
//   those zeros; queue and pipeline come up empty.
// ---------------------------------------------------------------------------
// sliding_median_velocity_filter: running median of a velocity stream
// Front keeps the sample window plus a pairwise order matrix; a two-slot
// queue decouples it from the back, which turns matrix rows into ranks and
// outputs the entry of rank WINDOW/2.
// ---------------------------------------------------------------------------
module sliding_median_velocity_filter #(
	parameter int unsigned WINDOW       = 11,
	parameter int unsigned SAMPLE_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [SAMPLE_WIDTH-1:0] velocity_sample,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [SAMPLE_WIDTH-1:0] filtered_velocity
);

	localparam int unsigned SNAP_W = WINDOW * SAMPLE_WIDTH + WINDOW * WINDOW;

	// snapshot of window and order matrix after each beat
	logic                                push_valid;
	logic                                push_ready;
	logic [WINDOW-1:0][SAMPLE_WIDTH-1:0] push_window;
	logic [WINDOW-1:0][WINDOW-1:0]       push_order;
	logic                                pop_valid;
	logic                                pop_ready;
	logic [WINDOW-1:0][SAMPLE_WIDTH-1:0] pop_window;
	logic [WINDOW-1:0][WINDOW-1:0]       pop_order;
	logic [SNAP_W-1:0]                   pop_data;

	// front: shift in the beat, compare it with the older entries
	smvf_front #(
		.WINDOW       (WINDOW),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.velocity_sample (velocity_sample),
		.push_valid      (push_valid),
		.push_ready      (push_ready),
		.push_window     (push_window),
		.push_order      (push_order)
	);

	// two-deep queue lets the front run while the output stalls
	smvf_queue #(
		.DATA_W (SNAP_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_window, push_order}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign pop_window = pop_data[SNAP_W-1 -: WINDOW*SAMPLE_WIDTH];
	assign pop_order  = pop_data[WINDOW*WINDOW-1:0];

	// back: row popcount gives each entry's rank; pick the middle one
	smvf_back #(
		.WINDOW       (WINDOW),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.pop_valid         (pop_valid),
		.pop_ready         (pop_ready),
		.pop_window        (pop_window),
		.pop_order         (pop_order),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.filtered_velocity (filtered_velocity)
	);

endmodule

>>> sv/smvf_front.sv
// ---------------------------------------------------------------------------
// smvf_front: sample window and pairwise order matrix
// Shifts each new beat into the window, compares it against the surviving
// entries and hands the updated window and order matrix to the queue.
// ---------------------------------------------------------------------------
module smvf_front #(
	parameter int unsigned WINDOW       = 11,
	parameter int unsigned SAMPLE_WIDTH = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic [SAMPLE_WIDTH-1:0]                   velocity_sample,
	output logic                                      push_valid,
	input  logic                                      push_ready,
	output logic [WINDOW-1:0][SAMPLE_WIDTH-1:0]       push_window,
	output logic [WINDOW-1:0][WINDOW-1:0]             push_order
);

	// order_q[i][j] set: entry j ranks below entry i (ties broken by age)
	logic [WINDOW-1:0][SAMPLE_WIDTH-1:0] window_q;
	logic [WINDOW-1:0][WINDOW-1:0]       order_q;
	logic [WINDOW-1:0][SAMPLE_WIDTH-1:0] window_nxt;
	logic [WINDOW-1:0][WINDOW-1:0]       order_nxt;
	logic                                take;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign take       = in_valid & push_ready;

	always_comb begin
		window_nxt[0] = velocity_sample;
		for (int i = 1; i < WINDOW; i++) begin
			window_nxt[i] = window_q[i-1];
		end
		order_nxt[0][0] = 1'b0;
		for (int j = 1; j < WINDOW; j++) begin
			// older entry equal to the new one ranks below it
			order_nxt[0][j] = $signed(window_q[j-1]) <= $signed(velocity_sample);
			order_nxt[j][0] = !($signed(window_q[j-1]) <= $signed(velocity_sample));
		end
		for (int i = 1; i < WINDOW; i++) begin
			for (int j = 1; j < WINDOW; j++) begin
				order_nxt[i][j] = order_q[i-1][j-1];
			end
		end
	end

	assign push_window = window_nxt;
	assign push_order  = order_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			// all zero: older index ranks below
			for (int i = 0; i < WINDOW; i++) begin
				for (int j = 0; j < WINDOW; j++) begin
					order_q[i][j] <= (j > i);
				end
			end
		end else if (take) begin
			window_q <= window_nxt;
			order_q  <= order_nxt;
		end
	end

endmodule

>>> sv/smvf_queue.sv
// ---------------------------------------------------------------------------
// smvf_queue: short FIFO between window update and median selection
// Holds snapshots so the front keeps taking beats while the back stalls, until the queue is full.
// ---------------------------------------------------------------------------
module smvf_queue #(
	parameter int unsigned DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [DATA_W-1:0] pop_data
);
	import smvf_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [QUEUE_DEPTH-1:0][DATA_W-1:0] slot_q;
	logic [PTR_W-1:0]                   wr_ptr_q;
	logic [PTR_W-1:0]                   rd_ptr_q;
	logic [CNT_W-1:0]                   count_q;
	logic                               do_push;
	logic                               do_pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> sv/smvf_back.sv
// ---------------------------------------------------------------------------
// smvf_back: rank count and median pick
// Counts each order row in two steps and selects the entry of middle rank.
// ---------------------------------------------------------------------------
module smvf_back #(
	parameter int unsigned WINDOW       = 11,
	parameter int unsigned SAMPLE_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pop_valid,
	output logic                                pop_ready,
	input  logic [WINDOW-1:0][SAMPLE_WIDTH-1:0] pop_window,
	input  logic [WINDOW-1:0][WINDOW-1:0]       pop_order,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [SAMPLE_WIDTH-1:0]             filtered_velocity
);
	import smvf_pkg::*;

	localparam logic [RANK_W-1:0] MID_RANK = RANK_W'(WINDOW / 2);

	logic                                       s1_valid_q;
	logic [WINDOW-1:0][SAMPLE_WIDTH-1:0]        win_s1;
	logic [WINDOW-1:0][GROUPS-1:0][PART_W-1:0]  part_s1;
	logic [WINDOW-1:0][GROUPS-1:0][PART_W-1:0]  part_nxt;
	logic                                       s2_valid_q;
	logic [WINDOW-1:0][SAMPLE_WIDTH-1:0]        win_s2;
	logic [WINDOW-1:0]                          hit_s2;
	logic [WINDOW-1:0]                          hit_nxt;
	logic [SAMPLE_WIDTH-1:0]                    pick;
	logic                                       out_valid_q;
	logic [SAMPLE_WIDTH-1:0]                    result_q;
	logic                                       out_free;
	logic                                       s2_free;
	logic                                       s1_free;

	assign out_free  = ~out_valid_q | out_ready;
	assign s2_free   = ~s2_valid_q | out_free;
	assign s1_free   = ~s1_valid_q | s2_free;
	assign pop_ready = s1_free;

	// partial popcounts, one per 8-bit group of each row
	always_comb begin
		logic [MAX_ROW-1:0] row;
		for (int i = 0; i < WINDOW; i++) begin
			row = MAX_ROW'(pop_order[i]);
			for (int g = 0; g < GROUPS; g++) begin
				part_nxt[i][g] = count8(row[g*GROUP_W +: GROUP_W]);
			end
		end
	end

	// rank is unique per entry, so exactly one hit
	always_comb begin
		logic [RANK_W-1:0] rank;
		for (int i = 0; i < WINDOW; i++) begin
			rank = '0;
			for (int g = 0; g < GROUPS; g++) begin
				rank = rank + RANK_W'(part_s1[i][g]);
			end
			hit_nxt[i] = rank == MID_RANK;
		end
	end

	always_comb begin
		pick = '0;
		for (int i = 0; i < WINDOW; i++) begin
			pick = pick | ({SAMPLE_WIDTH{hit_s2[i]}} & win_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			win_s1  <= pop_window;
			part_s1 <= part_nxt;
		end
		if (s2_free) begin
			win_s2 <= win_s1;
			hit_s2 <= hit_nxt;
		end
		if (out_free) begin
			result_q <= pick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_valid_q <= pop_valid;
			end
			if (s2_free) begin
				s2_valid_q <= s1_valid_q;
			end
			if (out_free) begin
				out_valid_q <= s2_valid_q;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign filtered_velocity = result_q;

endmodule
